[hw/rtl/hnf_pkg.sv]
`default_nettype none
package hnf_pkg;

  // grid and field sizes
  localparam int unsigned MAX_GRID = 1024;
  localparam int unsigned AW       = $clog2(MAX_GRID);
  localparam int unsigned GW       = AW + 1;
  localparam int unsigned HW       = 16;
  localparam int unsigned CSW      = 16;
  localparam int unsigned OW       = 16;
  // magnitude width of a vector component before scaling down
  localparam int unsigned MW       = 36;
  // output beat width, padded to bytes
  localparam int unsigned DW       = ((2 * AW + 9 * OW + 7) / 8) * 8;

  localparam logic [OW-1:0] ONE_Q14 = 16'd16384;

  // configuration register indexes
  localparam logic REG_GRID_SIZE    = 1'b0;
  localparam logic REG_CELL_SPACING = 1'b1;

  // job handed to the normalising sequencer
  typedef struct packed {
    logic               start;
    logic signed [16:0] d0;  // left minus right
    logic signed [16:0] d2;  // top minus bottom
    logic [16:0]        s2;  // twice the spacing
  } op_t;

  // nine components, normal x first
  typedef logic [8:0][OW-1:0] vec9_t;

  typedef struct packed {
    logic  done;
    vec9_t res;
  } res_t;

endpackage
`default_nettype wire

[hw/rtl/hnf_row_buf.sv]
`default_nettype none
module hnf_row_buf (
  input  wire                         clk_i,
  input  wire                         rd_en_i,
  input  wire  [hnf_pkg::AW-1:0]      rd_addr_i,
  input  wire                         wr_en_i,
  input  wire  [hnf_pkg::AW-1:0]      wr_addr_i,
  input  wire  [hnf_pkg::HW-1:0]      wr_above_i,
  input  wire  [hnf_pkg::HW-1:0]      wr_center_i,
  output logic [hnf_pkg::HW-1:0]      above_o,
  output logic [hnf_pkg::HW-1:0]      center_o,
  output logic [hnf_pkg::HW-1:0]      center_nx_o
);
  import hnf_pkg::*;

  logic [HW-1:0] row_above_mem  [MAX_GRID];
  logic [HW-1:0] row_center_mem [MAX_GRID];
  logic [AW-1:0] nx_addr;

  assign nx_addr = rd_addr_i + AW'(1);

  // registered reads: column, and column plus one of the centre row
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      above_o     <= row_above_mem[rd_addr_i];
      center_o    <= row_center_mem[rd_addr_i];
      center_nx_o <= row_center_mem[nx_addr];
    end
  end

  // rows shift down by one on each write
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      row_above_mem[wr_addr_i]  <= wr_above_i;
      row_center_mem[wr_addr_i] <= wr_center_i;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/hnf_mul.sv]
`default_nettype none
module hnf_mul (
  input  wire         clk_i,
  input  wire  [31:0] a_i,
  input  wire  [31:0] b_i,
  output logic [63:0] prod_o
);

  // shared unsigned multiplier, product registered
  always_ff @(posedge clk_i) begin
    prod_o <= 64'(a_i) * 64'(b_i);
  end

endmodule
`default_nettype wire

[hw/rtl/hnf_norm_seq.sv]
`default_nettype none
module hnf_norm_seq (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  hnf_pkg::op_t      op_i,
  output hnf_pkg::res_t     res_o
);
  import hnf_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_XM    = 13'b0000000000010,
    S_XA    = 13'b0000000000100,
    S_LOAD  = 13'b0000000001000,
    S_SHIFT = 13'b0000000010000,
    S_SQM   = 13'b0000000100000,
    S_SQA   = 13'b0000001000000,
    S_ZCHK  = 13'b0000010000000,
    S_TM    = 13'b0000100000000,
    S_TA    = 13'b0001000000000,
    S_BM1   = 13'b0010000000000,
    S_BM2   = 13'b0100000000000,
    S_BCMP  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  logic [1:0]  j_q, j_d;
  logic [1:0]  ci_q, ci_d;
  logic [1:0]  vi_q, vi_d;
  logic [3:0]  bit_q, bit_d;
  logic [14:0] k_q, k_d;
  logic        done_q, done_d;

  // operands of the current point
  logic [15:0] a0_q, a2_q;
  logic [16:0] s2_q;
  logic        n0_q, p0_q, n2_q;
  // bitangent magnitudes
  logic [MW-1:0] bt_q [3];
  // working vector
  logic [MW-1:0] wm_q [3];
  logic          wn_q [3];
  logic [31:0]   s_q;
  logic [59:0]   t_q;
  vec9_t         res_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [14:0] cand;
  logic        cand_ok;
  logic [14:0] lo;
  logic [15:0] lo16, enc;
  logic [3:0]  ridx;
  logic        too_big;

  hnf_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign cand    = k_q | (15'd1 << bit_q);
  assign cand_ok = (cand <= 15'd16384) && (prod <= {4'd0, t_q});
  assign lo      = cand_ok ? cand : k_q;
  assign lo16    = {1'b0, lo};
  assign enc     = wn_q[ci_q] ? (16'd0 - lo16) : lo16;
  assign ridx    = 4'(vi_q) * 4'd3 + 4'(ci_q);
  assign too_big = (wm_q[0][MW-1:15] != '0) || (wm_q[1][MW-1:15] != '0)
                || (wm_q[2][MW-1:15] != '0);

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_XM: begin
        unique case (j_q)
          2'd0: begin mul_a = 32'(a2_q); mul_b = 32'(a0_q); end
          2'd1: begin mul_a = 32'(a2_q); mul_b = 32'(s2_q); end
          2'd2: begin mul_a = 32'(a0_q); mul_b = 32'(a0_q); end
          default: begin mul_a = 32'(s2_q); mul_b = 32'(s2_q); end
        endcase
      end
      S_SQM: begin
        mul_a = 32'(wm_q[j_q][14:0]);
        mul_b = 32'(wm_q[j_q][14:0]);
      end
      S_TM: begin
        mul_a = 32'(wm_q[ci_q][14:0]);
        mul_b = 32'(wm_q[ci_q][14:0]);
      end
      S_BM1: begin
        mul_a = 32'({cand, 1'b0} - 16'd1);
        mul_b = 32'({cand, 1'b0} - 16'd1);
      end
      S_BM2: begin
        mul_a = 32'(prod[29:0]);
        mul_b = s_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer control
  always_comb begin
    state_d = state_q;
    j_d     = j_q;
    ci_d    = ci_q;
    vi_d    = vi_q;
    bit_d   = bit_q;
    k_d     = k_q;
    done_d  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (op_i.start) begin
          j_d     = 2'd0;
          state_d = S_XM;
        end
      end
      S_XM: state_d = S_XA;
      S_XA: begin
        if (j_q == 2'd3) begin
          vi_d    = 2'd0;
          state_d = S_LOAD;
        end else begin
          j_d     = j_q + 2'd1;
          state_d = S_XM;
        end
      end
      S_LOAD: state_d = S_SHIFT;
      S_SHIFT: begin
        if (!too_big) begin
          j_d     = 2'd0;
          state_d = S_SQM;
        end
      end
      S_SQM: state_d = S_SQA;
      S_SQA: begin
        if (j_q == 2'd2) begin
          state_d = S_ZCHK;
        end else begin
          j_d     = j_q + 2'd1;
          state_d = S_SQM;
        end
      end
      S_ZCHK: begin
        if (s_q == '0) begin
          if (vi_q == 2'd2) begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            vi_d    = vi_q + 2'd1;
            state_d = S_LOAD;
          end
        end else begin
          ci_d    = 2'd0;
          state_d = S_TM;
        end
      end
      S_TM: state_d = S_TA;
      S_TA: begin
        k_d     = '0;
        bit_d   = 4'd14;
        state_d = S_BM1;
      end
      S_BM1: state_d = S_BM2;
      S_BM2: state_d = S_BCMP;
      S_BCMP: begin
        k_d = lo;
        if (bit_q == 4'd0) begin
          if (ci_q == 2'd2) begin
            if (vi_q == 2'd2) begin
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else begin
              vi_d    = vi_q + 2'd1;
              state_d = S_LOAD;
            end
          end else begin
            ci_d    = ci_q + 2'd1;
            state_d = S_TM;
          end
        end else begin
          bit_d   = bit_q - 4'd1;
          state_d = S_BM1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      j_q     <= '0;
      ci_q    <= '0;
      vi_q    <= '0;
      bit_q   <= '0;
      k_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      ci_q    <= ci_d;
      vi_q    <= vi_d;
      bit_q   <= bit_d;
      k_q     <= k_d;
      done_q  <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (op_i.start) begin
          a0_q <= 16'(op_i.d0[16] ? -op_i.d0 : op_i.d0);
          a2_q <= 16'(op_i.d2[16] ? -op_i.d2 : op_i.d2);
          s2_q <= op_i.s2;
          n0_q <= op_i.d0[16];
          p0_q <= !op_i.d0[16] && (op_i.d0 != '0);
          n2_q <= op_i.d2[16];
        end
      end
      S_XA: begin
        unique case (j_q)
          2'd0: bt_q[0] <= MW'(prod);
          2'd1: bt_q[1] <= MW'(prod);
          2'd2: bt_q[2] <= MW'(prod);
          default: bt_q[2] <= bt_q[2] + MW'(prod);
        endcase
      end
      S_LOAD: begin
        unique case (vi_q)
          2'd0: begin
            wm_q[0] <= MW'(a0_q); wm_q[1] <= MW'(s2_q); wm_q[2] <= MW'(a2_q);
            wn_q[0] <= n0_q;      wn_q[1] <= 1'b0;      wn_q[2] <= n2_q;
          end
          2'd1: begin
            wm_q[0] <= MW'(s2_q); wm_q[1] <= MW'(a0_q); wm_q[2] <= '0;
            wn_q[0] <= 1'b0;      wn_q[1] <= p0_q;      wn_q[2] <= 1'b0;
          end
          default: begin
            wm_q[0] <= bt_q[0];   wm_q[1] <= bt_q[1];   wm_q[2] <= bt_q[2];
            wn_q[0] <= n2_q ^ n0_q; wn_q[1] <= n2_q;    wn_q[2] <= 1'b1;
          end
        endcase
      end
      S_SHIFT: begin
        if (too_big) begin
          wm_q[0] <= wm_q[0] >> 1;
          wm_q[1] <= wm_q[1] >> 1;
          wm_q[2] <= wm_q[2] >> 1;
        end
        s_q <= '0;
      end
      S_SQA: s_q <= s_q + prod[31:0];
      S_ZCHK: begin
        if (s_q == '0) begin
          res_q[4'(vi_q) * 4'd3]        <= '0;
          res_q[4'(vi_q) * 4'd3 + 4'd1] <= ONE_Q14;
          res_q[4'(vi_q) * 4'd3 + 4'd2] <= '0;
        end
      end
      S_TA: t_q <= {prod[29:0], 30'd0};
      S_BCMP: begin
        if (bit_q == 4'd0) begin
          res_q[ridx] <= enc;
        end
      end
      default: ;
    endcase
  end

  assign res_o.done = done_q;
  assign res_o.res  = res_q;

endmodule
`default_nettype wire

[hw/rtl/heightmap_normal_frame_unit.sv]
`default_nettype none
// channel   | dir | beat contents
// s_axis    | in  | tdata: height (16)
// m_axis    | out | tdata: point_col, point_row, normal xyz, tangent xyz, bitan xyz; tlast
// cfg       | in  | write enable, index (0 grid size, 1 cell spacing), data
//
// a first-row height passes from accept through the read state back to idle; a border
// point also passes through the hold state. an interior point computes the cross product
// terms, then per vector a load, shift-down steps, squaring, a zero check and, for a
// nonzero vector, a bit search per component on the one shared multiplier, then a handoff.
// reset clears counters and handshake state; the row buffers start unwritten.
// the output register lets the next height be accepted while a result waits.
module heightmap_normal_frame_unit (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // height
  input  wire  [15:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // point_col, point_row, normal_x/y/z, tangent_x/y/z, bitan_x/y/z, 4 zero bits
  output logic [hnf_pkg::DW-1:0] m_axis_tdata,
  output logic         m_axis_tlast,
  input  wire          cfg_we_i,
  input  wire          cfg_idx_i,
  input  wire  [15:0]  cfg_wdata_i
);
  import hnf_pkg::*;

  typedef enum logic [3:0] {
    T_IDLE = 4'b0001,
    T_READ = 4'b0010,
    T_CALC = 4'b0100,
    T_HOLD = 4'b1000
  } top_state_e;

  top_state_e state_q, state_d;

  logic [GW-1:0]  grid_size_q;
  logic [CSW-1:0] cell_spacing_q;
  logic [AW-1:0]  col_cnt_q, row_cnt_q;
  logic [HW-1:0]  left_hold_q;
  logic [HW-1:0]  h_q;
  logic [AW-1:0]  c_q, pr_q;
  logic           emit_q, border_q, last_q;
  vec9_t          res_q;
  logic           out_valid_q;
  logic [DW-1:0]  out_data_q;
  logic           out_last_q;

  logic           accept;
  logic [GW-1:0]  g, col_ext, row_tmp, row_fix, c_inc, r_inc;
  logic [AW-1:0]  c, r;
  logic [HW-1:0]  above, center, center_nx;
  logic           load_out;
  op_t            op;
  res_t           res;

  assign s_axis_tready = (state_q == T_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // effective grid size and current point
  always_comb begin
    if (grid_size_q < GW'(3))             g = GW'(3);
    else if (grid_size_q > GW'(MAX_GRID)) g = GW'(MAX_GRID);
    else                                  g = grid_size_q;
    col_ext = {1'b0, col_cnt_q};
    row_tmp = (col_ext >= g) ? ({1'b0, row_cnt_q} + GW'(1)) : {1'b0, row_cnt_q};
    row_fix = (row_tmp >= g) ? '0 : row_tmp;
    c       = (col_ext >= g) ? '0 : col_cnt_q;
    r       = row_fix[AW-1:0];
    c_inc   = {1'b0, c} + GW'(1);
    r_inc   = {1'b0, r} + GW'(1);
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q    <= GW'(256);
      cell_spacing_q <= CSW'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GRID_SIZE:    grid_size_q    <= cfg_wdata_i[GW-1:0];
        REG_CELL_SPACING: cell_spacing_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  hnf_row_buf u_row_buf (
    .clk_i       (clk_i),
    .rd_en_i     (accept),
    .rd_addr_i   (c),
    .wr_en_i     (state_q == T_READ),
    .wr_addr_i   (c_q),
    .wr_above_i  (center),
    .wr_center_i (h_q),
    .above_o     (above),
    .center_o    (center),
    .center_nx_o (center_nx)
  );

  // job for the normalising sequencer
  always_comb begin
    op.start = (state_q == T_READ) && emit_q && !border_q;
    op.d0    = $signed({left_hold_q[HW-1], left_hold_q})
             - $signed({center_nx[HW-1], center_nx});
    op.d2    = $signed({above[HW-1], above}) - $signed({h_q[HW-1], h_q});
    op.s2    = {cell_spacing_q, 1'b0};
  end

  hnf_norm_seq u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op),
    .res_o  (res)
  );

  assign load_out = (state_q == T_HOLD) && (!out_valid_q || m_axis_tready);

  // point sequencing
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_IDLE: if (accept) state_d = T_READ;
      T_READ: begin
        if (!emit_q)       state_d = T_IDLE;
        else if (border_q) state_d = T_HOLD;
        else               state_d = T_CALC;
      end
      T_CALC: if (res.done) state_d = T_HOLD;
      T_HOLD: if (load_out) state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      col_cnt_q   <= '0;
      row_cnt_q   <= '0;
      left_hold_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        if (c_inc >= g) begin
          col_cnt_q <= '0;
          row_cnt_q <= (r_inc >= g) ? '0 : r_inc[AW-1:0];
        end else begin
          col_cnt_q <= c_inc[AW-1:0];
          row_cnt_q <= r;
        end
      end
      if (state_q == T_READ) left_hold_q <= center;
      if (load_out)           out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // per point payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      h_q      <= s_axis_tdata;
      c_q      <= c;
      pr_q     <= r - AW'(1);
      emit_q   <= (r != '0);
      border_q <= (c == '0) || ({1'b0, c} == g - GW'(1)) || (r == AW'(1));
      last_q   <= ({1'b0, c} == g - GW'(1)) && ({1'b0, r} == g - GW'(1));
    end
    if (state_q == T_READ && border_q) begin
      for (int k = 0; k < 3; k++) begin
        res_q[3*k]     <= '0;
        res_q[3*k + 1] <= ONE_Q14;
        res_q[3*k + 2] <= '0;
      end
    end else if (state_q == T_CALC && res.done) begin
      res_q <= res.res;
    end
    if (load_out) begin
      out_data_q <= {4'd0, res_q, pr_q, c_q};
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire
